[src/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants of the masked patch SSD scorer.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int unsigned MaxRingItemsDef = 256;
  localparam int unsigned ColorBits       = 16;
  localparam int unsigned CoordW          = 12;
  localparam int unsigned DimW            = 13;
  localparam int unsigned MeanW           = 34;
  localparam int unsigned CountW          = 9;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [DimW-1:0] DimReset = DimW'(1024);

  // configuration register indexes
  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } mps_state_e;

  typedef struct packed {
    logic        [CoordW-1:0]    pixel_x;
    logic        [CoordW-1:0]    pixel_y;
    logic signed [CoordW-1:0]    shift_x;
    logic signed [CoordW-1:0]    shift_y;
    logic        [ColorBits-1:0] ref_red;
    logic        [ColorBits-1:0] ref_green;
    logic        [ColorBits-1:0] ref_blue;
    logic        [ColorBits-1:0] cand_red;
    logic        [ColorBits-1:0] cand_green;
    logic        [ColorBits-1:0] cand_blue;
    logic                        cand_damaged;
    logic                        last_in_ring;
  } mps_item_t;

endpackage

[src/mps_front.sv]
// ----------------------------------------------------------------------------
// mps_front
// Accepts ring pixels, checks bounds and damage, squares the channel
// differences and accumulates one ring total per ring.
// ----------------------------------------------------------------------------
module mps_front #(
  parameter int unsigned MaxRingItems = mps_pkg::MaxRingItemsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic                                        cfg_addr_i,
  input  logic [mps_pkg::DimW-1:0]                    cfg_wdata_i,
  input  logic                                        item_valid_i,
  output logic                                        item_ready_o,
  input  mps_pkg::mps_item_t                          item_i,
  input  logic [$clog2(mps_pkg::QueueDepth+1)-1:0]    level_i,
  output logic                                        ring_valid_o,
  output logic [2*mps_pkg::ColorBits+1+$clog2(MaxRingItems):0] ring_sum_o,
  output logic [$clog2(MaxRingItems+1)-1:0]           ring_used_o,
  output logic [$clog2(MaxRingItems+1)-1:0]           ring_cnt_o
);
  import mps_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxRingItems + 1);
  localparam int unsigned SumW  = 2 * ColorBits + 2 + $clog2(MaxRingItems);
  localparam int unsigned SqW   = 2 * ColorBits;
  localparam int unsigned LvlW  = $clog2(QueueDepth + 1);
  localparam int unsigned PosW  = CoordW + 2;

  logic [DimW-1:0] width_q, height_q;

  logic [CntW-1:0] ring_cnt_q, used_cnt_q;
  logic [CntW-1:0] ring_nxt, used_nxt;

  // stage 1
  logic                 s1_valid_q, s1_last_q, s1_use_q;
  logic [ColorBits-1:0] s1_dr_q, s1_dg_q, s1_db_q;
  logic [CntW-1:0]      s1_used_q, s1_ring_q;
  // stage 2
  logic                 s2_valid_q, s2_last_q;
  logic [SqW-1:0]       s2_sr_q, s2_sg_q, s2_sb_q;
  logic [CntW-1:0]      s2_used_q, s2_ring_q;

  logic [SumW-1:0] acc_q, term;

  logic                   accept, counted, in_image, use_px;
  logic signed [PosW-1:0] pos_x, pos_y;
  logic [LvlW:0]          committed;

  function automatic logic [ColorBits-1:0] absdiff(logic [ColorBits-1:0] a,
                                                   logic [ColorBits-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // a ring end needs a queue slot; count those already under way
  assign committed    = (LvlW+1)'(level_i) + (LvlW+1)'(s1_valid_q & s1_last_q)
                      + (LvlW+1)'(s2_valid_q & s2_last_q);
  assign item_ready_o = committed < (LvlW+1)'(QueueDepth);
  assign accept       = item_valid_i & item_ready_o;

  assign pos_x    = $signed({2'b00, item_i.pixel_x}) + PosW'(item_i.shift_x);
  assign pos_y    = $signed({2'b00, item_i.pixel_y}) + PosW'(item_i.shift_y);
  assign in_image = !pos_x[PosW-1] && !pos_y[PosW-1]
                 && (pos_x[DimW-1:0] < width_q) && (pos_y[DimW-1:0] < height_q);
  assign counted  = ring_cnt_q < CntW'(MaxRingItems);
  assign use_px   = counted & in_image & ~item_i.cand_damaged;
  assign ring_nxt = ring_cnt_q + CntW'(counted);
  assign used_nxt = used_cnt_q + CntW'(use_px);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgImageWidth:  width_q  <= cfg_wdata_i;
        CfgImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cnt_q <= '0;
      used_cnt_q <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      acc_q      <= '0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      if (accept) begin
        s1_last_q <= item_i.last_in_ring;
        if (item_i.last_in_ring) begin
          ring_cnt_q <= '0;
          used_cnt_q <= '0;
        end else begin
          ring_cnt_q <= ring_nxt;
          used_cnt_q <= used_nxt;
        end
      end
      if (s2_valid_q) begin
        acc_q <= s2_last_q ? '0 : (acc_q + term);
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_use_q  <= use_px;
      s1_dr_q   <= absdiff(item_i.ref_red,   item_i.cand_red);
      s1_dg_q   <= absdiff(item_i.ref_green, item_i.cand_green);
      s1_db_q   <= absdiff(item_i.ref_blue,  item_i.cand_blue);
      s1_used_q <= used_nxt;
      s1_ring_q <= ring_nxt;
    end
    if (s1_valid_q) begin
      s2_sr_q   <= s1_use_q ? SqW'(s1_dr_q) * SqW'(s1_dr_q) : '0;
      s2_sg_q   <= s1_use_q ? SqW'(s1_dg_q) * SqW'(s1_dg_q) : '0;
      s2_sb_q   <= s1_use_q ? SqW'(s1_db_q) * SqW'(s1_db_q) : '0;
      s2_used_q <= s1_used_q;
      s2_ring_q <= s1_ring_q;
    end
  end

  assign term = SumW'(s2_sr_q) + SumW'(s2_sg_q) + SumW'(s2_sb_q);

  assign ring_valid_o = s2_valid_q & s2_last_q;
  assign ring_sum_o   = acc_q + term;
  assign ring_used_o  = s2_used_q;
  assign ring_cnt_o   = s2_ring_q;

endmodule

[src/mps_fifo.sv]
// ----------------------------------------------------------------------------
// mps_fifo
// Short queue of ring totals between the front and the divider.
// ----------------------------------------------------------------------------
module mps_fifo #(
  parameter int unsigned Width = 60,
  parameter int unsigned Depth = mps_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       rd_i,
  output logic                       valid_o,
  output logic [Width-1:0]           rdata_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);
  import mps_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0]  level_q;
  logic             do_rd;

  assign do_rd   = rd_i & (level_q != '0);
  assign valid_o = level_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      level_q <= level_q + LvlW'(wr_i) - LvlW'(do_rd);
    end
  end

endmodule

[src/mps_back.sv]
// ----------------------------------------------------------------------------
// mps_back
// Takes one ring total, divides sum by used count one quotient bit per
// cycle (zero without a match) and holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module mps_back #(
  parameter int unsigned MaxRingItems = mps_pkg::MaxRingItemsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        ring_valid_i,
  output logic                                        ring_pop_o,
  input  logic [2*mps_pkg::ColorBits+1+$clog2(MaxRingItems):0] ring_sum_i,
  input  logic [$clog2(MaxRingItems+1)-1:0]           ring_used_i,
  input  logic [$clog2(MaxRingItems+1)-1:0]           ring_cnt_i,
  output logic                                        res_valid_o,
  input  logic                                        res_ready_i,
  output logic [mps_pkg::MeanW-1:0]                   mean_error_o,
  output logic                                        match_valid_o,
  output logic [mps_pkg::CountW-1:0]                  used_count_o
);
  import mps_pkg::*;

  localparam int unsigned CntW = $clog2(MaxRingItems + 1);
  localparam int unsigned SumW = 2 * ColorBits + 2 + $clog2(MaxRingItems);
  localparam int unsigned BitW = $clog2(SumW);

  mps_state_e state_q, state_d;

  logic [SumW-1:0] shreg_q;   // dividend in, quotient out
  logic [CntW-1:0] rem_q, div_q, used_q;
  logic            match_q;
  logic [BitW-1:0] bit_q;

  logic            load, step, last_bit, ge, match;
  logic [CntW:0]   rem_sh, rem_sub;

  assign match    = (ring_used_i != '0) && ({ring_used_i, 1'b0} >= {1'b0, ring_cnt_i});
  assign last_bit = bit_q == BitW'(SumW - 1);
  assign rem_sh   = {rem_q, shreg_q[SumW-1]};
  assign ge       = rem_sh >= {1'b0, div_q};
  assign rem_sub  = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    load        = 1'b0;
    step        = 1'b0;
    ring_pop_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (ring_valid_i) begin
          load       = 1'b1;
          ring_pop_o = 1'b1;
          state_d    = match ? StDiv : StDone;
        end
      end
      StDiv: begin
        step = 1'b1;
        if (last_bit) begin
          state_d = StDone;
        end
      end
      StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      shreg_q <= match ? ring_sum_i : '0;
      rem_q   <= '0;
      div_q   <= ring_used_i;
      used_q  <= ring_used_i;
      match_q <= match;
      bit_q   <= '0;
    end else if (step) begin
      shreg_q <= {shreg_q[SumW-2:0], ge};
      rem_q   <= ge ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      bit_q   <= bit_q + BitW'(1);
    end
  end

  assign mean_error_o  = MeanW'(shreg_q);
  assign match_valid_o = match_q;
  assign used_count_o  = CountW'(used_q);

endmodule

[src/masked_patch_ssd_top.sv]
// ----------------------------------------------------------------------------
// masked_patch_ssd_top
// Masked sum-of-squared-differences score of one candidate displacement.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  ----------------------------------
//  s_axis    in   s_axis_tvalid/tready    ring pixel, tuser=damaged, tlast
//  m_axis    out  m_axis_tvalid/tready    mean, used count, tuser=match
//  cfg       in   cfg_we_i                image width (0), height (1)
//
//  The front takes one ring pixel request per cycle while s_axis_tready is
//  high, through a two-stage square/accumulate pipe. Each ring end pushes a
//  total into a four-entry queue; the back divides one bit per cycle, skips
//  the division for a ring without a match, and takes a new ring when idle.
//  s_axis_tready drops only while the queue and the ring ends still in the
//  pipe fill all four slots. Reset clears control state; no clearing pass.
//
module masked_patch_ssd_top #(
  parameter int unsigned MaxRingItems = mps_pkg::MaxRingItemsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write
  input  logic                      cfg_we_i,
  input  logic                      cfg_addr_i,
  input  logic [mps_pkg::DimW-1:0]  cfg_wdata_i,
  // ring pixel requests
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], shift_x[35:24], shift_y[47:36],
  // ref_red[63:48], ref_green[79:64], ref_blue[95:80],
  // cand_red[111:96], cand_green[127:112], cand_blue[143:128]
  input  logic [143:0]              s_axis_tdata,
  input  logic [0:0]                s_axis_tuser,  // cand_damaged[0]
  input  logic                      s_axis_tlast,  // last_in_ring
  // results
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // mean_error[33:0], used_count[42:34], zero[47:43]
  output logic [47:0]               m_axis_tdata,
  output logic [0:0]                m_axis_tuser   // match_valid[0]
);
  import mps_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxRingItems + 1);
  localparam int unsigned SumW  = 2 * ColorBits + 2 + $clog2(MaxRingItems);
  localparam int unsigned QW    = SumW + 2 * CntW;
  localparam int unsigned LvlW  = $clog2(QueueDepth + 1);

  mps_item_t item;

  logic                ring_valid, ring_pop, q_valid;
  logic [SumW-1:0]     ring_sum, q_sum;
  logic [CntW-1:0]     ring_used, ring_cnt, q_used, q_cnt;
  logic [QW-1:0]       q_rdata;
  logic [LvlW-1:0]     q_level;

  logic [MeanW-1:0]    mean_error;
  logic [CountW-1:0]   used_count;
  logic                match_valid;

  // unpack the request fields
  assign item.pixel_x      = s_axis_tdata[11:0];
  assign item.pixel_y      = s_axis_tdata[23:12];
  assign item.shift_x      = s_axis_tdata[35:24];
  assign item.shift_y      = s_axis_tdata[47:36];
  assign item.ref_red      = s_axis_tdata[63:48];
  assign item.ref_green    = s_axis_tdata[79:64];
  assign item.ref_blue     = s_axis_tdata[95:80];
  assign item.cand_red     = s_axis_tdata[111:96];
  assign item.cand_green   = s_axis_tdata[127:112];
  assign item.cand_blue    = s_axis_tdata[143:128];
  assign item.cand_damaged = s_axis_tuser[0];
  assign item.last_in_ring = s_axis_tlast;

  mps_front #(
    .MaxRingItems(MaxRingItems)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_valid_i(s_axis_tvalid),
    .item_ready_o(s_axis_tready),
    .item_i      (item),
    .level_i     (q_level),
    .ring_valid_o(ring_valid),
    .ring_sum_o  (ring_sum),
    .ring_used_o (ring_used),
    .ring_cnt_o  (ring_cnt)
  );

  // queue entry: {ring count, used count, sum}
  mps_fifo #(
    .Width(QW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (ring_valid),
    .wdata_i({ring_cnt, ring_used, ring_sum}),
    .rd_i   (ring_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata),
    .level_o(q_level)
  );

  assign q_sum  = q_rdata[SumW-1:0];
  assign q_used = q_rdata[SumW+CntW-1:SumW];
  assign q_cnt  = q_rdata[QW-1:SumW+CntW];

  mps_back #(
    .MaxRingItems(MaxRingItems)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ring_valid_i (q_valid),
    .ring_pop_o   (ring_pop),
    .ring_sum_i   (q_sum),
    .ring_used_i  (q_used),
    .ring_cnt_i   (q_cnt),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .mean_error_o (mean_error),
    .match_valid_o(match_valid),
    .used_count_o (used_count)
  );

  assign m_axis_tdata = {5'b0, used_count, mean_error};
  assign m_axis_tuser = match_valid;

endmodule
